/* hdl/open_addressing_hash_table_assert.svh */
// assertion macros for the open addressing hash table
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define OAHT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("hash table invariant violated");
`define OAHT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hash table implication violated");
`else
`define OAHT_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define OAHT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/oaht_pkg.sv */
// shared types, codes and constants of the open addressing hash table
// no dependencies
package oaht_pkg;

	localparam int KEY_W      = 31;
	localparam int TIME_W     = 16;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int SLOT_OUT_W = 10;
	// key / 1000 of a 31-bit key fits 22 bits
	localparam int QUOT_W     = 22;

	localparam int DEF_TABLE_SLOTS = 1024;
	localparam int DEF_HASH_PRIME  = 1031;

	// key / 1000 by reciprocal: floor(2^40 / 1000), estimate low by at most one
	localparam int unsigned KEY_DIVISOR = 1000;
	localparam longint unsigned KEY_RECIP = 64'd1099511627;
	localparam int RECIP_SHIFT = 40;
	localparam int RECIP_W = 31;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic              used;
		logic              tomb;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] tval;
	} entry_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE
	} ctl_state_t;

	typedef enum logic [2:0] {
		H_IDLE,
		H_RECIP,
		H_CORR,
		H_MULT,
		H_MOD,
		H_WRAP
	} hash_state_t;

endpackage

/* hdl/oaht_hash.sv */
// home slot unit: ((a*(key/1000)+b) mod P) mod M via reciprocal, correction, multiply, remainder and wrap states
// depends on oaht_pkg
module oaht_hash #(
	parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS,
	parameter int HASH_PRIME  = oaht_pkg::DEF_HASH_PRIME
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [oaht_pkg::KEY_W-1:0]     key,
	output logic                           done,
	output logic [$clog2(TABLE_SLOTS)-1:0] home
);

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int A_W    = $clog2(TABLE_SLOTS + 1);
	localparam int V_W    = oaht_pkg::QUOT_W + A_W + 1;
	localparam int HASH_A = TABLE_SLOTS - TABLE_SLOTS / 2;
	localparam int HASH_B = TABLE_SLOTS - TABLE_SLOTS / 3;
	localparam int DIG    = 4;
	localparam int NDIG   = (V_W + DIG - 1) / DIG;
	localparam int VP_W   = NDIG * DIG;
	localparam int CNT_W  = $clog2(NDIG);
	localparam int RW     = $clog2(HASH_PRIME) + 1;
	localparam int PROD_W = oaht_pkg::KEY_W + oaht_pkg::RECIP_W;

	oaht_pkg::hash_state_t state_q, state_d;

	logic [oaht_pkg::KEY_W-1:0]  key_q;
	logic [oaht_pkg::QUOT_W-1:0] qest_q;
	logic [oaht_pkg::QUOT_W-1:0] k_q;
	logic [VP_W-1:0]             vsh_q;
	logic [RW-1:0]               rem_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [SLOT_W-1:0]           home_q;
	logic                        done_q;

	logic [PROD_W-1:0]           prod;
	logic [31:0]                 back;
	logic [31:0]                 resid;
	logic [oaht_pkg::QUOT_W-1:0] k_d;
	logic [V_W-1:0]              v_d;
	logic [RW-1:0]               rem_d;
	logic [SLOT_W-1:0]           home_d;

	always_comb begin
		prod  = PROD_W'(key_q) * PROD_W'(oaht_pkg::KEY_RECIP);
		back  = 32'(qest_q) * 32'(oaht_pkg::KEY_DIVISOR);
		resid = 32'(key_q) - back;
		k_d   = (resid >= 32'(oaht_pkg::KEY_DIVISOR)) ? qest_q + 1'b1 : qest_q;
		v_d   = V_W'(HASH_A) * V_W'(k_q) + V_W'(HASH_B);
	end

	// restoring remainder, DIG bits a cycle
	always_comb begin
		rem_d = rem_q;
		for (int i = 0; i < DIG; i++) begin
			rem_d = {rem_d[RW-2:0], vsh_q[VP_W-1-i]};
			if (rem_d >= RW'(HASH_PRIME))
				rem_d = rem_d - RW'(HASH_PRIME);
		end
	end

	// P lies below 2M, so one subtract folds into the table
	assign home_d = (rem_q >= RW'(TABLE_SLOTS)) ? SLOT_W'(rem_q - RW'(TABLE_SLOTS))
	                                            : SLOT_W'(rem_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oaht_pkg::H_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == oaht_pkg::H_WRAP);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oaht_pkg::H_IDLE:  if (start) state_d = oaht_pkg::H_RECIP;
			oaht_pkg::H_RECIP: state_d = oaht_pkg::H_CORR;
			oaht_pkg::H_CORR:  state_d = oaht_pkg::H_MULT;
			oaht_pkg::H_MULT:  state_d = oaht_pkg::H_MOD;
			oaht_pkg::H_MOD:   if (cnt_q == '0) state_d = oaht_pkg::H_WRAP;
			oaht_pkg::H_WRAP:  state_d = oaht_pkg::H_IDLE;
			default:           state_d = oaht_pkg::H_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == oaht_pkg::H_IDLE && start)
			key_q <= key;
		if (state_q == oaht_pkg::H_RECIP)
			qest_q <= prod[oaht_pkg::RECIP_SHIFT+oaht_pkg::QUOT_W-1:oaht_pkg::RECIP_SHIFT];
		if (state_q == oaht_pkg::H_CORR)
			k_q <= k_d;
		if (state_q == oaht_pkg::H_MULT) begin
			vsh_q <= VP_W'(v_d);
			rem_q <= '0;
			cnt_q <= CNT_W'(NDIG - 1);
		end
		if (state_q == oaht_pkg::H_MOD) begin
			vsh_q <= vsh_q << DIG;
			rem_q <= rem_d;
			cnt_q <= cnt_q - 1'b1;
		end
		if (state_q == oaht_pkg::H_WRAP)
			home_q <= home_d;
	end

	assign done = done_q;
	assign home = home_q;

endmodule

/* hdl/open_addressing_hash_table.sv */
// open addressing hash table, linear probing with tombstones; one op at a time.
// the hash unit finds the home slot, its remainder step taking 4 bits a cycle, then the
// table is probed one probe per cycle through the table memory's single read port.
// next op may start in the strobe cycle.
// an unknown op code returns its result in the cycle after acceptance.
// after reset a clearing pass over every slot holds busy high; results cannot be stalled.
`include "open_addressing_hash_table_assert.svh"

module open_addressing_hash_table #(
	parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS,
	parameter int HASH_PRIME  = oaht_pkg::DEF_HASH_PRIME
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// command side: a word is taken when start is high and busy low
	input  logic                              start,
	output logic                              busy,
	input  logic [oaht_pkg::OP_W-1:0]         op,
	input  logic [oaht_pkg::KEY_W-1:0]        key_id,
	input  logic [oaht_pkg::TIME_W-1:0]       payload_time,
	// result side: one word for exactly one cycle while done is high
	output logic                              done,
	output logic [oaht_pkg::STATUS_W-1:0]     status,
	output logic [oaht_pkg::SLOT_OUT_W-1:0]   slot_index,
	output logic [oaht_pkg::TIME_W-1:0]       stored_time
);

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int LC_W   = $clog2(TABLE_SLOTS + 1);
	localparam int OUT_W  = oaht_pkg::SLOT_OUT_W;

	// table memory: key, payload and the used and tombstone flags in one word
	oaht_pkg::entry_t mem [TABLE_SLOTS];
	oaht_pkg::entry_t rd_q;

	oaht_pkg::ctl_state_t state_q, state_d;

	// clearing pass address
	logic [SLOT_W-1:0] clr_q;

	// the op in flight
	logic [oaht_pkg::OP_W-1:0]   op_q;
	logic [oaht_pkg::KEY_W-1:0]  key_q;
	logic [oaht_pkg::TIME_W-1:0] time_q;

	// probe position and number of probes already made
	logic [SLOT_W-1:0] cur_q, cur_d;
	logic [SLOT_W-1:0] cnt_q, cnt_d;
	logic [SLOT_W-1:0] nxt;

	logic [LC_W-1:0] live_count_q;

	// result word register
	logic                          done_q;
	logic [oaht_pkg::STATUS_W-1:0] status_q;
	logic [OUT_W-1:0]              slot_q;
	logic [oaht_pkg::TIME_W-1:0]   stime_q;

	// hash unit
	logic              h_start;
	logic              h_done;
	logic [SLOT_W-1:0] h_home;

	// combinational controls
	logic                          accept;
	logic                          wr_en;
	logic [SLOT_W-1:0]             wr_addr;
	oaht_pkg::entry_t              wr_data;
	logic                          rd_en;
	logic [SLOT_W-1:0]             rd_addr;
	logic                          res_load;
	logic [oaht_pkg::STATUS_W-1:0] res_status;
	logic [OUT_W-1:0]              res_slot;
	logic [oaht_pkg::TIME_W-1:0]   res_time;
	logic                          lc_inc;
	logic                          lc_dec;
	logic                          live;
	logic                          key_eq;
	logic                          last;
	logic                          stop;
	logic [SLOT_W+OUT_W-1:0]       cur_ext;

	assign busy   = (state_q != oaht_pkg::S_IDLE);
	assign accept = start && !busy;

	oaht_hash #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.HASH_PRIME  (HASH_PRIME)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (h_start),
		.key    (key_id),
		.done   (h_done),
		.home   (h_home)
	);

	// probe step helpers
	assign nxt     = (cur_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : cur_q + 1'b1;
	assign live    = rd_q.used && !rd_q.tomb;
	assign key_eq  = (rd_q.key == key_q);
	assign last    = (cnt_q == SLOT_W'(TABLE_SLOTS - 1));
	// slot number widened or cut to the result field
	assign cur_ext = {{OUT_W{1'b0}}, cur_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= oaht_pkg::S_CLEAR;
			clr_q        <= '0;
			live_count_q <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_load;
			if (state_q == oaht_pkg::S_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (lc_inc)
				live_count_q <= live_count_q + 1'b1;
			else if (lc_dec && live_count_q != '0)
				live_count_q <= live_count_q - 1'b1;
		end
	end

	always_comb begin
		state_d    = state_q;
		h_start    = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = cur_q;
		wr_data    = '0;
		rd_en      = 1'b0;
		rd_addr    = nxt;
		cur_d      = cur_q;
		cnt_d      = cnt_q;
		res_load   = 1'b0;
		res_status = oaht_pkg::ST_MISSING;
		res_slot   = '0;
		res_time   = '0;
		lc_inc     = 1'b0;
		lc_dec     = 1'b0;
		stop       = 1'b0;
		unique case (state_q)
			oaht_pkg::S_CLEAR: begin
				// drop used and tombstone flags of every slot
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == SLOT_W'(TABLE_SLOTS - 1))
					state_d = oaht_pkg::S_IDLE;
			end
			oaht_pkg::S_IDLE: begin
				if (accept) begin
					if (op == oaht_pkg::OP_INSERT || op == oaht_pkg::OP_SEARCH ||
					    op == oaht_pkg::OP_DELETE) begin
						h_start = 1'b1;
						state_d = oaht_pkg::S_HASH;
					end else begin
						// unknown code: not found at once, no state change
						res_load = 1'b1;
					end
				end
			end
			oaht_pkg::S_HASH: begin
				if (h_done) begin
					rd_en   = 1'b1;
					rd_addr = h_home;
					cur_d   = h_home;
					cnt_d   = '0;
					state_d = oaht_pkg::S_PROBE;
				end
			end
			oaht_pkg::S_PROBE: begin
				// rd_q holds the slot at cur_q
				unique case (op_q) inside
					oaht_pkg::OP_INSERT: begin
						if (!live || key_eq) begin
							stop         = 1'b1;
							wr_en        = 1'b1;
							wr_data.used = 1'b1;
							wr_data.tomb = 1'b0;
							wr_data.key  = key_q;
							wr_data.tval = time_q;
							lc_inc       = !live;
							res_status   = oaht_pkg::ST_OK;
							res_slot     = cur_ext[OUT_W-1:0];
						end else if (last) begin
							stop       = 1'b1;
							res_status = oaht_pkg::ST_FULL;
						end
					end
					oaht_pkg::OP_SEARCH, oaht_pkg::OP_DELETE: begin
						if (!rd_q.used) begin
							stop = 1'b1;
						end else if (live && key_eq) begin
							stop       = 1'b1;
							res_status = oaht_pkg::ST_OK;
							res_slot   = cur_ext[OUT_W-1:0];
							if (op_q == oaht_pkg::OP_SEARCH) begin
								res_time = rd_q.tval;
							end else begin
								// tombstone keeps the key and payload
								wr_en        = 1'b1;
								wr_data      = rd_q;
								wr_data.tomb = 1'b1;
								lc_dec       = 1'b1;
							end
						end else if (last) begin
							stop = 1'b1;
						end
					end
					default: stop = 1'b1;
				endcase
				if (stop) begin
					res_load = 1'b1;
					state_d  = oaht_pkg::S_IDLE;
				end else begin
					rd_en = 1'b1;
					cur_d = nxt;
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: state_d = oaht_pkg::S_IDLE;
		endcase
	end

	// table memory with one write port and one read port, read data registered into rd_q
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	// request, probe and result registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			key_q  <= key_id;
			time_q <= payload_time;
		end
		cur_q <= cur_d;
		cnt_q <= cnt_d;
		if (res_load) begin
			status_q <= res_status;
			slot_q   <= res_slot;
			stime_q  <= res_time;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign slot_index  = slot_q;
	assign stored_time = stime_q;

	// the result word always comes out with the controller back at rest
	`OAHT_ASSERT_IMPLY(a_done_idle, clk, arst_n, done_q, state_q == oaht_pkg::S_IDLE)
	// live entries never outnumber the slots
	`OAHT_ASSERT_ALWAYS(a_live_bound, clk, arst_n, live_count_q <= LC_W'(TABLE_SLOTS))
	// a hash result only arrives while the controller waits for it
	`OAHT_ASSERT_IMPLY(a_hash_wait, clk, arst_n, h_done, state_q == oaht_pkg::S_HASH)

endmodule

/* verif/oaht_reply_checker.sv */
// reply checker for the open addressing hash table: keeps its own copy of the table,
// predicts the reply to every accepted command word and compares the replies in order
// depends on oaht_pkg
module oaht_reply_checker
	import oaht_pkg::*;
#(
	parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
	parameter int HASH_PRIME  = DEF_HASH_PRIME
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [OP_W-1:0]       op,
	input  logic [KEY_W-1:0]      key_id,
	input  logic [TIME_W-1:0]     payload_time,
	input  logic                  done,
	input  logic [STATUS_W-1:0]   status,
	input  logic [SLOT_OUT_W-1:0] slot_index,
	input  logic [TIME_W-1:0]     stored_time,
	output int                    fail_count,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [SLOT_OUT_W-1:0] slot;
		logic [TIME_W-1:0]     stime;
	} reply_t;

	reply_t awaited_replies[$];
	int     replies_seen;

	// shadow table
	logic [KEY_W-1:0]  tab_key  [TABLE_SLOTS];
	logic [TIME_W-1:0] tab_time [TABLE_SLOTS];
	bit                tab_used [TABLE_SLOTS];
	bit                tab_tomb [TABLE_SLOTS];
	int                live_entries;

	function automatic int home_of(input logic [KEY_W-1:0] k);
		longint unsigned m, a, b, q;
		m = TABLE_SLOTS;
		a = m - m / 2;
		b = m - m / 3;
		q = longint'(k) / KEY_DIVISOR;
		return int'(((a * q + b) % HASH_PRIME) % m);
	endfunction

	// live entry with this key, tombstones skipped, stops at an unused slot or after a wrap
	function automatic bit locate_live(input logic [KEY_W-1:0] k, output int where);
		int s;
		s = home_of(k);
		where = 0;
		for (int n = 0; n < TABLE_SLOTS; n++) begin
			if (!tab_used[s])
				return 1'b0;
			if (!tab_tomb[s] && tab_key[s] == k) begin
				where = s;
				return 1'b1;
			end
			s = (s + 1) % TABLE_SLOTS;
		end
		return 1'b0;
	endfunction

	task automatic predict_reply(input logic [OP_W-1:0] o, input logic [KEY_W-1:0] k,
			input logic [TIME_W-1:0] t, output reply_t r);
		int  s;
		bit  live;
		r.status = ST_MISSING;
		r.slot   = '0;
		r.stime  = '0;
		case (o)
			OP_INSERT: begin
				s = home_of(k);
				r.status = ST_FULL;
				for (int n = 0; n < TABLE_SLOTS; n++) begin
					live = tab_used[s] && !tab_tomb[s];
					if (!live || tab_key[s] == k) begin
						if (!live)
							live_entries++;
						tab_key[s]  = k;
						tab_time[s] = t;
						tab_used[s] = 1'b1;
						tab_tomb[s] = 1'b0;
						r.status = ST_OK;
						r.slot   = SLOT_OUT_W'(s);
						break;
					end
					s = (s + 1) % TABLE_SLOTS;
				end
			end
			OP_SEARCH: begin
				if (locate_live(k, s)) begin
					r.status = ST_OK;
					r.slot   = SLOT_OUT_W'(s);
					r.stime  = tab_time[s];
				end
			end
			OP_DELETE: begin
				if (locate_live(k, s)) begin
					tab_tomb[s] = 1'b1;
					if (live_entries > 0)
						live_entries--;
					r.status = ST_OK;
					r.slot   = SLOT_OUT_W'(s);
				end
			end
			default: ;
		endcase
	endtask

	task automatic note_failure(input string what, input reply_t want);
		fail_count++;
		if (fail_count <= 10)
			$display("%s at reply %0d: expected status %0d slot %0d time %h, got status %0d slot %0d time %h",
				what, replies_seen, want.status, want.slot, want.stime,
				status, slot_index, stored_time);
	endtask

	initial begin
		fail_count  = 0;
		outstanding = 0;
		replies_seen = 0;
	end

	// sampled mid-cycle, where inputs and outputs are settled for the coming edge
	always @(negedge clk) begin
		reply_t want;
		reply_t got;
		if (!arst_n) begin
			foreach (tab_used[i]) begin
				tab_used[i] = 1'b0;
				tab_tomb[i] = 1'b0;
				tab_key[i]  = '0;
				tab_time[i] = '0;
			end
			live_entries = 0;
		end else begin
			if (done === 1'b1) begin
				got = '{status: status, slot: slot_index, stime: stored_time};
				if (awaited_replies.size() == 0) begin
					note_failure("reply with nothing awaited", '0);
				end else begin
					want = awaited_replies.pop_front();
					if (got.status !== want.status || got.slot !== want.slot
							|| got.stime !== want.stime)
						note_failure("reply mismatch", want);
				end
				replies_seen++;
			end
			if (start === 1'b1 && busy === 1'b0) begin
				predict_reply(op, key_id, payload_time, want);
				awaited_replies.push_back(want);
			end
			outstanding = awaited_replies.size();
		end
	end

endmodule

/* verif/tb_open_addressing_hash_table.sv */
// testbench top for the open addressing hash table: drives command words, runs the
// watchdog and gives the verdict; replies are predicted and checked by oaht_reply_checker
// depends on oaht_pkg, open_addressing_hash_table and oaht_reply_checker
module tb_open_addressing_hash_table;
	timeunit 1ns;
	timeprecision 1ps;
	import oaht_pkg::*;

	localparam int SLOTS = DEF_TABLE_SLOTS;
	localparam int PRIME = DEF_HASH_PRIME;
	// quotients 0 .. PRIME-1 give distinct hash residues, so a fill over them spreads out
	localparam int FILL_WORDS = PRIME;
	// a reply can take a full wrap of probes plus the hash; the clearing pass is one slot a cycle
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int TAIL_CYCLES = SLOTS + 64;

	// op code the block does not know
	localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

	// keys used by the directed words; every key in 5000 .. 5999 shares one home slot
	localparam logic [KEY_W-1:0] KEY_LOW_A  = 31'd5000;
	localparam logic [KEY_W-1:0] KEY_LOW_B  = 31'd5007;
	localparam logic [KEY_W-1:0] KEY_LOW_C  = 31'd5011;
	// quotient 492 lands on the last slot, so a second key there wraps round to slot zero
	localparam logic [KEY_W-1:0] KEY_EDGE_A = 31'd492000;
	localparam logic [KEY_W-1:0] KEY_EDGE_B = 31'd492001;
	localparam logic [KEY_W-1:0] KEY_TOP    = {KEY_W{1'b1}};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [OP_W-1:0]       op = OP_SEARCH;
	logic [KEY_W-1:0]      key_id = '0;
	logic [TIME_W-1:0]     payload_time = '0;
	logic                  busy;
	logic                  done;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic [TIME_W-1:0]     stored_time;

	int fail_count;
	int outstanding;
	int idle_cycles = 0;
	bit gaps_on = 1'b1;

	// small set of quotients so that random keys pile up on a few home slots
	int pool_q[6] = '{0, 5, 492, 100, 101, 1030};
	logic [OP_W-1:0] real_ops[3] = '{OP_INSERT, OP_SEARCH, OP_DELETE};
	int fill_q[FILL_WORDS];
	logic [KEY_W-1:0] fill_keys[FILL_WORDS];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	open_addressing_hash_table #(
		.TABLE_SLOTS(SLOTS),
		.HASH_PRIME (PRIME)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.key_id      (key_id),
		.payload_time(payload_time),
		.done        (done),
		.status      (status),
		.slot_index  (slot_index),
		.stored_time (stored_time)
	);

	oaht_reply_checker #(
		.TABLE_SLOTS(SLOTS),
		.HASH_PRIME (PRIME)
	) reply_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.key_id      (key_id),
		.payload_time(payload_time),
		.done        (done),
		.status      (status),
		.slot_index  (slot_index),
		.stored_time (stored_time),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// idle time before the next word: mostly none, now and then a long pause
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (!gaps_on || p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// key from the crowded pool: a shared quotient and a small remainder
	function automatic logic [KEY_W-1:0] pool_key();
		return KEY_W'(pool_q[$urandom_range(0, 5)] * KEY_DIVISOR + $urandom_range(0, 31));
	endfunction

	// top bit set keeps these clear of every pool and fill key
	function automatic logic [KEY_W-1:0] stray_key();
		return {1'b1, 30'($urandom)};
	endfunction

	function automatic logic [TIME_W-1:0] any_time();
		return TIME_W'($urandom);
	endfunction

	// present one command word, hold it until the block takes it, then idle for the given gap
	task automatic issue(input logic [OP_W-1:0] o, input logic [KEY_W-1:0] k,
			input logic [TIME_W-1:0] t, input int gap);
		start        <= 1'b1;
		op           <= o;
		key_id       <= k;
		payload_time <= t;
		// busy seen mid-cycle is the value the coming edge will use
		do @(negedge clk); while (busy);
		@(posedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off the sender until every reply is back
	task automatic drain();
		start <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// watchdog: cycles with neither a command word taken nor a reply word seen
	always @(negedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int p;
		int j;
		int tmp;
		logic [KEY_W-1:0] k;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, unknown op, extreme keys and payloads
		issue(OP_SEARCH, KEY_LOW_A, 16'h0000, pick_gap());
		issue(OP_DELETE, KEY_LOW_A, 16'hffff, pick_gap());
		issue(OP_UNKNOWN, KEY_TOP, 16'hffff, pick_gap());
		issue(OP_INSERT, '0, 16'h0000, pick_gap());
		issue(OP_INSERT, KEY_TOP, 16'hffff, pick_gap());
		issue(OP_SEARCH, '0, 16'h0000, pick_gap());
		issue(OP_SEARCH, KEY_TOP, 16'h0000, pick_gap());
		// overwrite of a live key in place
		issue(OP_INSERT, '0, 16'h1234, pick_gap());
		issue(OP_SEARCH, '0, 16'h0000, pick_gap());
		// collision chain, then a tombstone in front of a live key
		issue(OP_INSERT, KEY_LOW_A, 16'haaaa, pick_gap());
		issue(OP_INSERT, KEY_LOW_B, 16'h5555, pick_gap());
		issue(OP_DELETE, KEY_LOW_A, 16'h0000, pick_gap());
		issue(OP_SEARCH, KEY_LOW_B, 16'h0000, pick_gap());
		issue(OP_SEARCH, KEY_LOW_A, 16'h0000, pick_gap());
		// reinsert of a live key lying past a tombstone takes the tombstone: two copies live
		issue(OP_INSERT, KEY_LOW_B, 16'h0f0f, pick_gap());
		issue(OP_DELETE, KEY_LOW_B, 16'h0000, pick_gap());
		issue(OP_SEARCH, KEY_LOW_B, 16'h0000, pick_gap());
		issue(OP_INSERT, KEY_LOW_C, 16'h8001, pick_gap());
		// probing wraps from the last slot to slot zero
		issue(OP_INSERT, KEY_EDGE_A, any_time(), pick_gap());
		issue(OP_INSERT, KEY_EDGE_B, any_time(), pick_gap());
		issue(OP_SEARCH, KEY_EDGE_B, 16'h0000, pick_gap());
		issue(OP_DELETE, KEY_EDGE_A, 16'h0000, pick_gap());
		issue(OP_SEARCH, KEY_EDGE_B, 16'h0000, pick_gap());
		issue(OP_DELETE, KEY_TOP, 16'h0000, pick_gap());
		issue(OP_SEARCH, KEY_TOP, 16'h0000, pick_gap());
		drain();

		// random traffic on a crowded key pool: long chains, many tombstones
		for (int i = 0; i < 460; i++) begin
			if (i % 40 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			p = $urandom_range(0, 99);
			if (p < 44)
				issue(OP_INSERT, pool_key(), any_time(), pick_gap());
			else if (p < 72)
				issue(OP_SEARCH, pool_key(), any_time(), pick_gap());
			else if (p < 92)
				issue(OP_DELETE, pool_key(), any_time(), pick_gap());
			else if (p < 96)
				issue(OP_UNKNOWN, stray_key(), any_time(), pick_gap());
			else
				issue(real_ops[$urandom_range(0, 2)], stray_key(), any_time(), pick_gap());
		end
		drain();

		// fill: more distinct keys than slots, so the table ends up full and later inserts fail
		foreach (fill_q[i])
			fill_q[i] = i;
		for (int i = FILL_WORDS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = fill_q[i];
			fill_q[i] = fill_q[j];
			fill_q[j] = tmp;
		end
		foreach (fill_keys[i]) begin
			// remainders from 500 up never meet a pool key
			fill_keys[i] = KEY_W'(fill_q[i] * KEY_DIVISOR + $urandom_range(500, 999));
			if (i % 40 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			issue(OP_INSERT, fill_keys[i], any_time(), pick_gap());
		end
		drain();

		// full table: lookups, deletes and reuse of the tombstones they leave
		gaps_on = 1'b1;
		for (int i = 0; i < 140; i++) begin
			p = $urandom_range(0, 99);
			k = fill_keys[$urandom_range(0, FILL_WORDS - 1)];
			if (p < 30)
				issue(OP_SEARCH, k, any_time(), pick_gap());
			else if (p < 50)
				issue(OP_DELETE, k, any_time(), pick_gap());
			else if (p < 70)
				issue(OP_INSERT, k, any_time(), pick_gap());
			else if (p < 80)
				issue(OP_INSERT, pool_key(), any_time(), pick_gap());
			else if (p < 88)
				issue(OP_SEARCH, stray_key(), any_time(), pick_gap());
			else if (p < 94)
				issue(OP_SEARCH, pool_key(), any_time(), pick_gap());
			else
				issue(OP_UNKNOWN, k, any_time(), pick_gap());
		end

		drain();
		// room for any stray reply word after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/oaht_pkg.sv
hdl/oaht_hash.sv
hdl/open_addressing_hash_table.sv
verif/oaht_reply_checker.sv
verif/tb_open_addressing_hash_table.sv
